@@ rtl/core/fidalloc_pkg.sv @@
// shared types and constants for the fifo id allocator
package fidalloc_pkg;

    localparam int CMD_W       = 3;
    localparam int COUNT_W     = 5;
    localparam int REL_ID_W    = 10;
    localparam int ID_OUT_W    = 10;
    localparam int STATUS_W    = 2;
    localparam int AMOUNT_W    = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE_ACTIVE = 3'd0,
        CMD_CREATE_IDLE   = 3'd1,
        CMD_GET           = 3'd2,
        CMD_GET_OR_CREATE = 3'd3,
        CMD_RELEASE       = 3'd4,
        CMD_RELEASE_ALL   = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FEW_IDLE   = 2'd1,
        ST_EXHAUSTED  = 2'd2,
        ST_NOT_ACTIVE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_FILL,
        OP_NEW_ACT,
        OP_NEW_IDLE,
        OP_POP_RD,
        OP_POP_EMIT,
        OP_REL_RD,
        OP_REL_EMIT,
        OP_WALK_RD,
        OP_WALK_CHK,
        OP_WALK_END,
        OP_FAIL
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status fail_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_zero;
        logic             fresh_short;
        logic             idle_short;
        logic             need_short;
        logic             rid_ok;
        logic             rem_last;
        logic             need_last;
        logic             walk_done;
        logic             out_free;
    } t_dp_status;

endpackage

@@ rtl/core/fidalloc_ram.sv @@
// generic single write port ram with registered read
module fidalloc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fidalloc_dpath.sv @@
// allocator datapath: counters, idle fifo, active bitmap and result register
module fidalloc_dpath import fidalloc_pkg::*; #(
    parameter int NUM_IDS   = 1024,
    parameter int MAX_BATCH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [REL_ID_W-1:0] i_release_id,
    input  t_dp_cmd             i_ctl,
    output t_dp_status          o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [ID_OUT_W-1:0] o_id_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [AMOUNT_W-1:0] o_amount,
    output logic                o_last
);

    localparam int IW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);
    localparam int BW = $clog2(MAX_BATCH + 1);
    localparam logic [IW-1:0] LAST_ID = IW'(NUM_IDS - 1);

    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [BW-1:0]       r_cnt, n_cnt;
    logic [REL_ID_W-1:0] r_rid, n_rid;
    logic [CW-1:0]       r_nf, n_nf;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_level, n_level;
    logic [BW-1:0]       r_rem, n_rem;
    logic [BW-1:0]       r_need, n_need;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_moved, n_moved;
    logic                r_out_valid, n_out_valid;
    logic [ID_OUT_W-1:0] r_out_id, n_out_id;
    t_status             r_out_status, n_out_status;
    logic [AMOUNT_W-1:0] r_out_amount, n_out_amount;
    logic                r_out_last, n_out_last;

    logic [CW-1:0]          fresh_left;
    logic [31:0]            need_w;
    logic [IW-1:0]          nf_id, idx_id, rid_id;
    logic [IW+REL_ID_W-1:0] rid_ext;
    logic [IW+ID_OUT_W-1:0] nf_ext, q_ext;
    logic [ID_OUT_W-1:0]    nf_out, q_out;
    logic [BW+AMOUNT_W-1:0] cnt_ext;
    logic [CW+AMOUNT_W-1:0] moved_ext;
    logic [AMOUNT_W-1:0]    cnt_amt, moved_amt;
    logic [IW-1:0]          head_inc, tail_inc;
    logic                   out_free, emit, push, pop;

    logic          q_we, q_re;
    logic [IW-1:0] q_wdata, q_rdata;
    logic          m_we, m_re, m_wdata, m_rdata;
    logic [IW-1:0] m_waddr, m_raddr;

    assign fresh_left = CW'(NUM_IDS) - r_nf;
    assign need_w     = 32'(r_cnt) - 32'(r_level);
    assign nf_id      = r_nf[IW-1:0];
    assign idx_id     = r_idx[IW-1:0];
    assign rid_ext    = {IW'(0), r_rid};
    assign rid_id     = rid_ext[IW-1:0];
    assign nf_ext     = {ID_OUT_W'(0), nf_id};
    assign nf_out     = nf_ext[ID_OUT_W-1:0];
    assign q_ext      = {ID_OUT_W'(0), q_rdata};
    assign q_out      = q_ext[ID_OUT_W-1:0];
    assign cnt_ext    = {AMOUNT_W'(0), r_cnt};
    assign cnt_amt    = cnt_ext[AMOUNT_W-1:0];
    assign moved_ext  = {AMOUNT_W'(0), r_moved};
    assign moved_amt  = moved_ext[AMOUNT_W-1:0];
    assign head_inc   = (r_head == LAST_ID) ? '0 : r_head + IW'(1);
    assign tail_inc   = (r_tail == LAST_ID) ? '0 : r_tail + IW'(1);
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_sts.cmd         = r_cmd;
    assign o_sts.cnt_zero    = (r_cnt == '0);
    assign o_sts.fresh_short = 32'(fresh_left) < 32'(r_cnt);
    assign o_sts.idle_short  = 32'(r_level) < 32'(r_cnt);
    assign o_sts.need_short  = 32'(fresh_left) < need_w;
    assign o_sts.rid_ok      = 32'(r_rid) < 32'(r_nf);
    assign o_sts.rem_last    = (r_rem == BW'(1));
    assign o_sts.need_last   = (r_need == BW'(1));
    assign o_sts.walk_done   = (r_idx == r_nf);
    assign o_sts.out_free    = out_free;

    always_comb begin
        n_cmd        = r_cmd;
        n_cnt        = r_cnt;
        n_rid        = r_rid;
        n_nf         = r_nf;
        n_head       = r_head;
        n_tail       = r_tail;
        n_level      = r_level;
        n_rem        = r_rem;
        n_need       = r_need;
        n_idx        = r_idx;
        n_moved      = r_moved;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        n_out_amount = r_out_amount;
        n_out_last   = r_out_last;
        emit         = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        q_we         = 1'b0;
        q_wdata      = nf_id;
        q_re         = 1'b0;
        m_we         = 1'b0;
        m_waddr      = nf_id;
        m_wdata      = 1'b0;
        m_re         = 1'b0;
        m_raddr      = rid_id;

        case (i_ctl.op)
            OP_LOAD: begin
                n_cmd = i_cmd;
                n_rid = i_release_id;
                if (32'(i_count) > MAX_BATCH) begin
                    n_cnt = BW'(MAX_BATCH);
                end else begin
                    n_cnt = BW'(i_count);
                end
            end
            OP_DECODE: begin
                n_rem   = r_cnt;
                n_need  = BW'(need_w);
                n_idx   = '0;
                n_moved = '0;
            end
            OP_FILL: begin
                // top up the idle fifo from the fresh counter
                q_we   = 1'b1;
                m_we   = 1'b1;
                push   = 1'b1;
                n_nf   = r_nf + CW'(1);
                n_need = r_need - BW'(1);
            end
            OP_NEW_ACT, OP_NEW_IDLE: begin
                m_we    = 1'b1;
                m_wdata = (i_ctl.op == OP_NEW_ACT);
                q_we    = (i_ctl.op == OP_NEW_IDLE);
                push    = (i_ctl.op == OP_NEW_IDLE);
                n_nf    = r_nf + CW'(1);
                n_rem   = r_rem - BW'(1);
                emit    = 1'b1;
                n_out_id     = nf_out;
                n_out_status = ST_OK;
                n_out_amount = cnt_amt;
                n_out_last   = (r_rem == BW'(1));
            end
            OP_POP_RD: begin
                q_re = 1'b1;
            end
            OP_POP_EMIT: begin
                m_we    = 1'b1;
                m_waddr = q_rdata;
                m_wdata = 1'b1;
                pop     = 1'b1;
                n_rem   = r_rem - BW'(1);
                emit    = 1'b1;
                n_out_id     = q_out;
                n_out_status = ST_OK;
                n_out_amount = cnt_amt;
                n_out_last   = (r_rem == BW'(1));
            end
            OP_REL_RD: begin
                m_re    = 1'b1;
                m_raddr = rid_id;
            end
            OP_REL_EMIT: begin
                emit       = 1'b1;
                n_out_last = 1'b1;
                if (m_rdata) begin
                    m_we    = 1'b1;
                    m_waddr = rid_id;
                    q_we    = 1'b1;
                    q_wdata = rid_id;
                    push    = 1'b1;
                    n_out_id     = r_rid;
                    n_out_status = ST_OK;
                    n_out_amount = AMOUNT_W'(1);
                end else begin
                    n_out_id     = '0;
                    n_out_status = ST_NOT_ACTIVE;
                    n_out_amount = '0;
                end
            end
            OP_WALK_RD: begin
                m_re    = 1'b1;
                m_raddr = idx_id;
            end
            OP_WALK_CHK: begin
                // active ids go to the fifo tail in ascending order
                n_idx = r_idx + CW'(1);
                if (m_rdata) begin
                    m_we    = 1'b1;
                    m_waddr = idx_id;
                    q_we    = 1'b1;
                    q_wdata = idx_id;
                    push    = 1'b1;
                    n_moved = r_moved + CW'(1);
                end
            end
            OP_WALK_END: begin
                emit         = 1'b1;
                n_out_id     = '0;
                n_out_status = ST_OK;
                n_out_amount = moved_amt;
                n_out_last   = 1'b1;
            end
            OP_FAIL: begin
                emit         = 1'b1;
                n_out_id     = '0;
                n_out_status = i_ctl.fail_status;
                n_out_amount = '0;
                n_out_last   = 1'b1;
            end
            default: begin
            end
        endcase

        if (push) begin
            n_tail  = tail_inc;
            n_level = r_level + CW'(1);
        end
        if (pop) begin
            n_head  = head_inc;
            n_level = r_level - CW'(1);
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_nf        <= n_nf;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cnt        <= n_cnt;
        r_rid        <= n_rid;
        r_rem        <= n_rem;
        r_need       <= n_need;
        r_idx        <= n_idx;
        r_moved      <= n_moved;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_amount <= n_out_amount;
        r_out_last   <= n_out_last;
    end

    fidalloc_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_IDS)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // bitmap entries below the fresh counter are always written before read
    fidalloc_ram #(
        .WIDTH (1),
        .DEPTH (NUM_IDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_id_out    = r_out_id;
    assign o_status    = r_out_status;
    assign o_amount    = r_out_amount;
    assign o_last      = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result word loaded over an untaken word");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_level) <= NUM_IDS)
        else $error("idle fifo level beyond id space");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nf) <= NUM_IDS)
        else $error("fresh counter beyond id space");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((32'(r_head) + 32'(r_level) >= NUM_IDS) ?
            (32'(r_head) + 32'(r_level) - NUM_IDS) :
            (32'(r_head) + 32'(r_level))) == 32'(r_tail))
        else $error("idle fifo pointers disagree with level");

endmodule

@@ rtl/core/fidalloc_ctrl.sv @@
// allocator controller state machine
module fidalloc_ctrl import fidalloc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_ctl
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_FILL     = 12'b0000_0000_0100,
        S_NEW_ID   = 12'b0000_0000_1000,
        S_POP_RD   = 12'b0000_0001_0000,
        S_POP_EMIT = 12'b0000_0010_0000,
        S_REL_RD   = 12'b0000_0100_0000,
        S_REL_EMIT = 12'b0000_1000_0000,
        S_WALK_RD  = 12'b0001_0000_0000,
        S_WALK_CHK = 12'b0010_0000_0000,
        S_WALK_END = 12'b0100_0000_0000,
        S_FAIL     = 12'b1000_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_fail_st, n_fail_st;

    always_comb begin
        n_state           = r_state;
        n_fail_st         = r_fail_st;
        o_ctl.op          = OP_NONE;
        o_ctl.fail_status = r_fail_st;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.op = OP_DECODE;
                case (t_cmd'(i_sts.cmd))
                    CMD_RELEASE: begin
                        if (i_sts.rid_ok) begin
                            n_state = S_REL_RD;
                        end else begin
                            n_fail_st = ST_NOT_ACTIVE;
                            n_state   = S_FAIL;
                        end
                    end
                    CMD_RELEASE_ALL: begin
                        n_state = S_WALK_RD;
                    end
                    CMD_CREATE_ACTIVE, CMD_CREATE_IDLE: begin
                        if (i_sts.cnt_zero) begin
                            n_fail_st = ST_OK;
                            n_state   = S_FAIL;
                        end else if (i_sts.fresh_short) begin
                            n_fail_st = ST_EXHAUSTED;
                            n_state   = S_FAIL;
                        end else begin
                            n_state = S_NEW_ID;
                        end
                    end
                    CMD_GET: begin
                        if (i_sts.cnt_zero) begin
                            n_fail_st = ST_OK;
                            n_state   = S_FAIL;
                        end else if (i_sts.idle_short) begin
                            n_fail_st = ST_FEW_IDLE;
                            n_state   = S_FAIL;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    CMD_GET_OR_CREATE: begin
                        if (i_sts.cnt_zero) begin
                            n_fail_st = ST_OK;
                            n_state   = S_FAIL;
                        end else if (i_sts.idle_short && i_sts.need_short) begin
                            n_fail_st = ST_EXHAUSTED;
                            n_state   = S_FAIL;
                        end else if (i_sts.idle_short) begin
                            n_state = S_FILL;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    default: begin
                        // unused codes give no result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FILL: begin
                o_ctl.op = OP_FILL;
                if (i_sts.need_last) begin
                    n_state = S_POP_RD;
                end
            end
            S_NEW_ID: begin
                if (i_sts.out_free) begin
                    o_ctl.op = (t_cmd'(i_sts.cmd) == CMD_CREATE_ACTIVE) ?
                               OP_NEW_ACT : OP_NEW_IDLE;
                    if (i_sts.rem_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_POP_RD: begin
                o_ctl.op = OP_POP_RD;
                n_state  = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_POP_EMIT;
                    n_state  = i_sts.rem_last ? S_IDLE : S_POP_RD;
                end
            end
            S_REL_RD: begin
                o_ctl.op = OP_REL_RD;
                n_state  = S_REL_EMIT;
            end
            S_REL_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_REL_EMIT;
                    n_state  = S_IDLE;
                end
            end
            S_WALK_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_WALK_END;
                end else begin
                    o_ctl.op = OP_WALK_RD;
                    n_state  = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                o_ctl.op = OP_WALK_CHK;
                n_state  = S_WALK_RD;
            end
            S_WALK_END: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_WALK_END;
                    n_state  = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_FAIL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fail_st <= n_fail_st;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/core/fifo_id_allocator_unit.sv @@
// fifo id allocator top level: stream ports, controller and datapath
// flow: an accepted command is loaded, then decoded; a create registers one result word per id,
// a get reads each id from the idle fifo and then emits it, and an in-range release reads the
// bitmap and then emits; get_or_create first tops up the idle fifo from the fresh counter, and
// release_all walks every created id before its summary word; one command at a time
// reset: synchronous active low; clears counters, fifo pointers and fsm, no ram pass
module fifo_id_allocator_unit import fidalloc_pkg::*; #(
    parameter int NUM_IDS   = 1024,
    parameter int MAX_BATCH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [2:0] cmd, [7:3] count, [17:8] release_id, [23:18] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [9:0] id_out, [11:10] status, [22:12] amount, [23] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    t_dp_cmd             ctl;
    t_dp_status          sts;
    logic [ID_OUT_W-1:0] id_out;
    logic [STATUS_W-1:0] status;
    logic [AMOUNT_W-1:0] amount;

    fidalloc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    fidalloc_dpath #(
        .NUM_IDS   (NUM_IDS),
        .MAX_BATCH (MAX_BATCH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_s_axis_tdata[2:0]),
        .i_count      (i_s_axis_tdata[7:3]),
        .i_release_id (i_s_axis_tdata[17:8]),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_id_out     (id_out),
        .o_status     (status),
        .o_amount     (amount),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, amount, status, id_out};

endmodule
